>>> design/mcs_pkg.sv
// Shared types and constants for the motor command sequencer.
// No dependencies; every other design file refers to it by scoped names.
package mcs_pkg;

   localparam int NUM_MOTORS  = 5;
   localparam int MOTOR_IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int MOTOR_W     = 3;
   localparam int SPEED_W     = 12;
   localparam int DIR_W       = 2;

   localparam logic [SPEED_W-1:0] SPEED_LIMIT_RESET = 12'd2400;

   // Signed direction codes as raw bits
   localparam logic [DIR_W-1:0] DIR_CODE_FWD = 2'b01;
   localparam logic [DIR_W-1:0] DIR_CODE_BWD = 2'b11;

   // Stored direction
   localparam logic DIR_FORWARD  = 1'b0;
   localparam logic DIR_BACKWARD = 1'b1;

   localparam logic FUNC_SET  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef enum logic [1:0] {
      ACT_IDLE  = 2'd0,
      ACT_SPEED = 2'd1,
      ACT_DIR   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIR,
      ST_SPEED,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic                   set_en;
      logic                   eval_dir;
      logic                   eval_speed;
      logic                   flush;
      logic [MOTOR_IDX_W-1:0] motor;
   } ctl_cmd_type;

endpackage

>>> design/mcs_ctrl.sv
// Sequencer control: walks the motors in two phases per motor on a tick.
// Depends on mcs_pkg; drives the command struct for mcs_datapath.
module mcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_func,
   output logic                 busy,
   output mcs_pkg::ctl_cmd_type cmd
);

   mcs_pkg::state_type                 state_ff;
   mcs_pkg::state_type                 state_in;
   logic [mcs_pkg::MOTOR_IDX_W-1:0]    motor_ff;
   logic [mcs_pkg::MOTOR_IDX_W-1:0]    motor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcs_pkg::ST_IDLE;
         motor_ff <= '0;
      end else begin
         state_ff <= state_in;
         motor_ff <= motor_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      motor_in       = motor_ff;
      busy           = 1'b1;
      cmd.set_en     = 1'b0;
      cmd.eval_dir   = 1'b0;
      cmd.eval_speed = 1'b0;
      cmd.flush      = 1'b0;
      cmd.motor      = motor_ff;
      case (state_ff)
         mcs_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_func == mcs_pkg::FUNC_TICK) begin
                  state_in = mcs_pkg::ST_DIR;
                  motor_in = '0;
               end else begin
                  cmd.set_en = 1'b1;
               end
            end
         end
         mcs_pkg::ST_DIR: begin
            cmd.eval_dir = 1'b1;
            state_in     = mcs_pkg::ST_SPEED;
         end
         mcs_pkg::ST_SPEED: begin
            cmd.eval_speed = 1'b1;
            if (motor_ff == mcs_pkg::MOTOR_IDX_W'(mcs_pkg::NUM_MOTORS - 1)) begin
               state_in = mcs_pkg::ST_FLUSH;
            end else begin
               motor_in = motor_ff + 1'b1;
               state_in = mcs_pkg::ST_DIR;
            end
         end
         mcs_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = mcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = mcs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/mcs_datapath.sv
// Per-motor state, command checking, tick evaluation and result holding.
// Depends on mcs_pkg; driven by the command struct from mcs_ctrl.
module mcs_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  mcs_pkg::ctl_cmd_type           cmd,
   input  logic [2:0]                     req_motor_index,
   input  logic [mcs_pkg::SPEED_W-1:0]    req_speed,
   input  logic signed [1:0]              req_direction,
   input  logic                           csr_wr_en,
   input  logic [mcs_pkg::SPEED_W-1:0]    csr_wr_data,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_action,
   output logic [mcs_pkg::MOTOR_W-1:0]    rsp_out_motor,
   output logic [mcs_pkg::SPEED_W-1:0]    rsp_value,
   output logic                           rsp_last
);

   localparam int N = mcs_pkg::NUM_MOTORS;

   logic [mcs_pkg::SPEED_W-1:0] limit_ff, limit_in;

   logic                        adir_ff [N];
   logic                        adir_in [N];
   logic [mcs_pkg::SPEED_W-1:0] aspd_ff [N];
   logic [mcs_pkg::SPEED_W-1:0] aspd_in [N];
   logic                        pdv_ff  [N];
   logic                        pdv_in  [N];
   logic                        pdir_ff [N];
   logic                        pdir_in [N];
   logic                        psv_ff  [N];
   logic                        psv_in  [N];
   logic [mcs_pkg::SPEED_W-1:0] pspd_ff [N];
   logic [mcs_pkg::SPEED_W-1:0] pspd_in [N];

   logic changed_ff, changed_in;

   // One-deep hold so the final result of a tick can be marked last
   logic                        hold_v_ff, hold_v_in;
   mcs_pkg::action_type         hold_act_ff, hold_act_in;
   logic [mcs_pkg::MOTOR_W-1:0] hold_mot_ff, hold_mot_in;
   logic [mcs_pkg::SPEED_W-1:0] hold_val_ff, hold_val_in;

   logic                        out_v_ff, out_v_in;
   mcs_pkg::action_type         out_act_ff, out_act_in;
   logic [mcs_pkg::MOTOR_W-1:0] out_mot_ff, out_mot_in;
   logic [mcs_pkg::SPEED_W-1:0] out_val_ff, out_val_in;
   logic                        out_last_ff, out_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= mcs_pkg::SPEED_LIMIT_RESET;
         changed_ff <= 1'b0;
         hold_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
         for (int i = 0; i < N; i++) begin
            adir_ff[i] <= mcs_pkg::DIR_FORWARD;
            aspd_ff[i] <= '0;
            pdv_ff[i]  <= 1'b0;
            pdir_ff[i] <= mcs_pkg::DIR_FORWARD;
            psv_ff[i]  <= 1'b0;
            pspd_ff[i] <= '0;
         end
      end else begin
         limit_ff   <= limit_in;
         changed_ff <= changed_in;
         hold_v_ff  <= hold_v_in;
         out_v_ff   <= out_v_in;
         for (int i = 0; i < N; i++) begin
            adir_ff[i] <= adir_in[i];
            aspd_ff[i] <= aspd_in[i];
            pdv_ff[i]  <= pdv_in[i];
            pdir_ff[i] <= pdir_in[i];
            psv_ff[i]  <= psv_in[i];
            pspd_ff[i] <= pspd_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_act_ff <= hold_act_in;
      hold_mot_ff <= hold_mot_in;
      hold_val_ff <= hold_val_in;
      out_act_ff  <= out_act_in;
      out_mot_ff  <= out_mot_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
   end

   // Set and tick evaluation on the per-motor state
   logic                            set_ok;
   logic                            cmd_ok;
   logic [mcs_pkg::MOTOR_IDX_W-1:0] sidx;
   logic [mcs_pkg::MOTOR_IDX_W-1:0] m;
   logic                            cand_v;
   mcs_pkg::action_type             cand_act;
   logic [mcs_pkg::SPEED_W-1:0]     cand_val;

   always_comb begin
      set_ok   = ({1'b0, req_motor_index} < 4'(N));
      cmd_ok   = ((req_direction[1:0] == mcs_pkg::DIR_CODE_FWD)
                  || (req_direction[1:0] == mcs_pkg::DIR_CODE_BWD))
                 && (req_speed <= limit_ff);
      sidx     = req_motor_index[mcs_pkg::MOTOR_IDX_W-1:0];
      m        = cmd.motor;
      cand_v   = 1'b0;
      cand_act = mcs_pkg::ACT_IDLE;
      cand_val = '0;
      changed_in = changed_ff;
      adir_in  = adir_ff;
      aspd_in  = aspd_ff;
      pdv_in   = pdv_ff;
      pdir_in  = pdir_ff;
      psv_in   = psv_ff;
      pspd_in  = pspd_ff;

      if (cmd.set_en && set_ok) begin
         pdv_in[sidx]  = 1'b1;
         psv_in[sidx]  = 1'b1;
         pspd_in[sidx] = cmd_ok ? req_speed : '0;
         pdir_in[sidx] = (cmd_ok && req_direction[1]) ? mcs_pkg::DIR_BACKWARD
                                                      : mcs_pkg::DIR_FORWARD;
      end

      if (cmd.eval_dir) begin
         changed_in = 1'b0;
         if (pdv_ff[m]) begin
            if (pdir_ff[m] == adir_ff[m]) begin
               pdv_in[m] = 1'b0;
            end else if (aspd_ff[m] != '0) begin
               // stop the motor first; direction follows on a later tick
               cand_v     = 1'b1;
               cand_act   = mcs_pkg::ACT_SPEED;
               aspd_in[m] = '0;
            end else begin
               cand_v     = 1'b1;
               cand_act   = mcs_pkg::ACT_DIR;
               cand_val   = mcs_pkg::SPEED_W'(pdir_ff[m]);
               adir_in[m] = pdir_ff[m];
               pdv_in[m]  = 1'b0;
               changed_in = 1'b1;
            end
         end
      end

      if (cmd.eval_speed) begin
         if (psv_ff[m] && (pspd_ff[m] == '0)) begin
            cand_v     = 1'b1;
            cand_act   = mcs_pkg::ACT_SPEED;
            aspd_in[m] = '0;
            psv_in[m]  = 1'b0;
         end else if (!pdv_ff[m] && psv_ff[m] && !changed_ff) begin
            cand_v     = 1'b1;
            cand_act   = mcs_pkg::ACT_SPEED;
            cand_val   = pspd_ff[m];
            aspd_in[m] = pspd_ff[m];
            psv_in[m]  = 1'b0;
         end
      end
   end

   // Result staging: a new candidate pushes the held beat out as not-last
   always_comb begin
      hold_v_in   = hold_v_ff;
      hold_act_in = hold_act_ff;
      hold_mot_in = hold_mot_ff;
      hold_val_in = hold_val_ff;
      out_v_in    = 1'b0;
      out_act_in  = hold_act_ff;
      out_mot_in  = hold_mot_ff;
      out_val_in  = hold_val_ff;
      out_last_in = 1'b0;
      if (cmd.flush) begin
         out_v_in    = 1'b1;
         out_last_in = 1'b1;
         hold_v_in   = 1'b0;
         if (!hold_v_ff) begin
            out_act_in = mcs_pkg::ACT_IDLE;
            out_mot_in = '0;
            out_val_in = '0;
         end
      end else if (cand_v) begin
         out_v_in    = hold_v_ff;
         hold_v_in   = 1'b1;
         hold_act_in = cand_act;
         hold_mot_in = mcs_pkg::MOTOR_W'(m);
         hold_val_in = cand_val;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_action    = out_act_ff;
   assign rsp_out_motor = out_mot_ff;
   assign rsp_value     = out_val_ff;
   assign rsp_last      = out_last_ff;

endmodule

>>> design/motor_command_sequencer_top.sv
// Motor command sequencer: a set leaves busy low and gives no beat. A tick
// keeps busy high while each motor in turn takes a direction step and then
// a speed step, and a last flush step closes the tick. Result beats appear
// on rsp_valid one cycle each; a beat is held until the next one (or the end
// of the tick) shows whether it is the last, and is then registered onto the
// outputs. The final beat, with rsp_last high, comes out in the first cycle
// in which busy is low again. The receiver cannot stall, so every beat must
// be taken in the cycle it is shown. A tick with nothing to write gives one
// idle beat.
// Depends on mcs_pkg, mcs_ctrl and mcs_datapath.
module motor_command_sequencer_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_func,
   input  logic [2:0]                   req_motor_index,
   input  logic [mcs_pkg::SPEED_W-1:0]  req_speed,
   input  logic signed [1:0]            req_direction,
   input  logic                         csr_wr_en,
   input  logic [mcs_pkg::SPEED_W-1:0]  csr_wr_data,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_action,
   output logic [mcs_pkg::MOTOR_W-1:0]  rsp_out_motor,
   output logic [mcs_pkg::SPEED_W-1:0]  rsp_value,
   output logic                         rsp_last
);

   mcs_pkg::ctl_cmd_type cmd;

   mcs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .busy     (busy),
      .cmd      (cmd)
   );

   mcs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_motor_index (req_motor_index),
      .req_speed       (req_speed),
      .req_direction   (req_direction),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_action      (rsp_action),
      .rsp_out_motor   (rsp_out_motor),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last)
   );

endmodule

>>> tb/sv/mcs_beat_checker.sv
`timescale 1ns / 100ps
// Beat checker for the motor command sequencer: watches the command, CSR and
// result channels, predicts the beats of every tick and compares them in order.
// Depends on mcs_pkg only.
module mcs_beat_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         req_func,
   input  logic [2:0]                   req_motor_index,
   input  logic [mcs_pkg::SPEED_W-1:0]  req_speed,
   input  logic signed [1:0]            req_direction,
   input  logic                         csr_wr_en,
   input  logic [mcs_pkg::SPEED_W-1:0]  csr_wr_data,
   input  logic                         rsp_valid,
   input  logic [1:0]                   rsp_action,
   input  logic [mcs_pkg::MOTOR_W-1:0]  rsp_out_motor,
   input  logic [mcs_pkg::SPEED_W-1:0]  rsp_value,
   input  logic                         rsp_last,
   output int                           mismatch_count,
   output int                           beats_due
);

   typedef struct packed {
      mcs_pkg::action_type          act;
      logic [mcs_pkg::MOTOR_W-1:0]  motor;
      logic [mcs_pkg::SPEED_W-1:0]  value;
      logic                         last;
   } motor_beat_type;

   motor_beat_type               beat_q[$];
   logic [mcs_pkg::SPEED_W-1:0]  speed_limit;
   logic                         applied_dir   [mcs_pkg::NUM_MOTORS];
   logic [mcs_pkg::SPEED_W-1:0]  applied_speed [mcs_pkg::NUM_MOTORS];
   logic                         dir_pending   [mcs_pkg::NUM_MOTORS];
   logic                         wanted_dir    [mcs_pkg::NUM_MOTORS];
   logic                         speed_pending [mcs_pkg::NUM_MOTORS];
   logic [mcs_pkg::SPEED_W-1:0]  wanted_speed  [mcs_pkg::NUM_MOTORS];
   int                           fail_total = 0;

   task automatic store_command(input logic [2:0] idx,
                                input logic [mcs_pkg::SPEED_W-1:0] spd,
                                input logic [1:0] dir_code);
      logic                        dir;
      logic [mcs_pkg::SPEED_W-1:0] kept;
      if (idx < mcs_pkg::NUM_MOTORS) begin
         // bad direction or over-limit speed collapses to stop, forward
         if ((dir_code == mcs_pkg::DIR_CODE_FWD || dir_code == mcs_pkg::DIR_CODE_BWD)
             && spd <= speed_limit) begin
            kept = spd;
            dir  = (dir_code == mcs_pkg::DIR_CODE_BWD) ? mcs_pkg::DIR_BACKWARD
                                                       : mcs_pkg::DIR_FORWARD;
         end else begin
            kept = '0;
            dir  = mcs_pkg::DIR_FORWARD;
         end
         wanted_speed[idx]  = kept;
         speed_pending[idx] = 1'b1;
         wanted_dir[idx]    = dir;
         dir_pending[idx]   = 1'b1;
      end
   endtask

   task automatic run_tick();
      mcs_pkg::action_type          acts [2*mcs_pkg::NUM_MOTORS];
      int                           who  [2*mcs_pkg::NUM_MOTORS];
      logic [mcs_pkg::SPEED_W-1:0]  vals [2*mcs_pkg::NUM_MOTORS];
      int                           n;
      logic                         turned;
      motor_beat_type               b;
      n = 0;
      for (int m = 0; m < mcs_pkg::NUM_MOTORS; m++) begin
         turned = 1'b0;
         if (dir_pending[m]) begin
            if (wanted_dir[m] == applied_dir[m]) begin
               dir_pending[m] = 1'b0;
            end else if (applied_speed[m] != '0) begin
               // stop first, turn on a later tick
               acts[n] = mcs_pkg::ACT_SPEED; who[n] = m; vals[n] = '0; n++;
               applied_speed[m] = '0;
            end else begin
               acts[n] = mcs_pkg::ACT_DIR; who[n] = m;
               vals[n] = {{(mcs_pkg::SPEED_W-1){1'b0}}, wanted_dir[m]}; n++;
               applied_dir[m] = wanted_dir[m];
               dir_pending[m] = 1'b0;
               turned = 1'b1;
            end
         end
         if (speed_pending[m] && wanted_speed[m] == '0) begin
            acts[n] = mcs_pkg::ACT_SPEED; who[n] = m; vals[n] = '0; n++;
            applied_speed[m] = '0;
            speed_pending[m] = 1'b0;
         end
         if (!dir_pending[m] && speed_pending[m] && !turned) begin
            acts[n] = mcs_pkg::ACT_SPEED; who[n] = m; vals[n] = wanted_speed[m]; n++;
            applied_speed[m] = wanted_speed[m];
            speed_pending[m] = 1'b0;
         end
      end
      if (n == 0) begin
         b.act = mcs_pkg::ACT_IDLE; b.motor = '0; b.value = '0; b.last = 1'b1;
         beat_q.push_back(b);
      end else begin
         for (int i = 0; i < n; i++) begin
            b.act   = acts[i];
            b.motor = who[i][mcs_pkg::MOTOR_W-1:0];
            b.value = vals[i];
            b.last  = (i == n - 1);
            beat_q.push_back(b);
         end
      end
   endtask

   task automatic check_beat();
      motor_beat_type want;
      if (beat_q.size() == 0) begin
         if (fail_total < 10)
            $display("%0t: beat with none due: action %0d motor %0d value %0d last %0d",
                     $time, rsp_action, rsp_out_motor, rsp_value, rsp_last);
         fail_total++;
      end else begin
         want = beat_q.pop_front();
         if (rsp_action !== want.act || rsp_out_motor !== want.motor ||
             rsp_value !== want.value || rsp_last !== want.last) begin
            if (fail_total < 10)
               $display({"%0t: beat mismatch: expected action %0d motor %0d value %0d ",
                         "last %0d, got action %0d motor %0d value %0d last %0d"},
                        $time, want.act, want.motor, want.value, want.last,
                        rsp_action, rsp_out_motor, rsp_value, rsp_last);
            fail_total++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         beat_q.delete();
         speed_limit = mcs_pkg::SPEED_LIMIT_RESET;
         for (int m = 0; m < mcs_pkg::NUM_MOTORS; m++) begin
            applied_dir[m]   = mcs_pkg::DIR_FORWARD;
            applied_speed[m] = '0;
            dir_pending[m]   = 1'b0;
            wanted_dir[m]    = mcs_pkg::DIR_FORWARD;
            speed_pending[m] = 1'b0;
            wanted_speed[m]  = '0;
         end
      end else begin
         // retire the beat on show before predicting a new command
         if (rsp_valid)
            check_beat();
         if (csr_wr_en)
            speed_limit = csr_wr_data;
         if (start && !busy) begin
            if (req_func == mcs_pkg::FUNC_TICK)
               run_tick();
            else
               store_command(req_motor_index, req_speed, req_direction);
         end
      end
      mismatch_count <= fail_total;
      beats_due      <= beat_q.size();
   end

endmodule

>>> tb/sv/motor_command_sequencer_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the motor command sequencer: drives commands, ticks and
// speed limit writes, and gives the verdict from the beat checker's counts.
// Depends on mcs_pkg, motor_command_sequencer_top and mcs_beat_checker.
module motor_command_sequencer_top_tb;

   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 470;
   localparam int LIMIT_STEPS  = 5;

   localparam logic [1:0] DIR_CODE_NONE = 2'b00;
   localparam logic [1:0] DIR_CODE_NEG2 = 2'b10;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_func;
   logic [2:0]                    req_motor_index;
   logic [mcs_pkg::SPEED_W-1:0]   req_speed;
   logic signed [1:0]             req_direction;
   logic                          csr_wr_en;
   logic [mcs_pkg::SPEED_W-1:0]   csr_wr_data;
   logic                          rsp_valid;
   logic [1:0]                    rsp_action;
   logic [mcs_pkg::MOTOR_W-1:0]   rsp_out_motor;
   logic [mcs_pkg::SPEED_W-1:0]   rsp_value;
   logic                          rsp_last;
   int                            mismatch_count;
   int                            beats_due;
   bit                            no_gaps;

   motor_command_sequencer_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_motor_index (req_motor_index),
      .req_speed       (req_speed),
      .req_direction   (req_direction),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_action      (rsp_action),
      .rsp_out_motor   (rsp_out_motor),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last)
   );

   mcs_beat_checker beat_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_motor_index (req_motor_index),
      .req_speed       (req_speed),
      .req_direction   (req_direction),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_action      (rsp_action),
      .rsp_out_motor   (rsp_out_motor),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last),
      .mismatch_count  (mismatch_count),
      .beats_due       (beats_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hold start across back-to-back commands; lower it only ahead of a gap.
   task automatic issue(input logic func, input logic [2:0] idx,
                        input logic [mcs_pkg::SPEED_W-1:0] spd, input logic [1:0] dir);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_func        <= func;
      req_motor_index <= idx;
      req_speed       <= spd;
      req_direction   <= dir;
      do @(posedge clock); while (busy);
   endtask

   task automatic set_cmd(input logic [2:0] idx, input logic [mcs_pkg::SPEED_W-1:0] spd,
                          input logic [1:0] dir);
      issue(mcs_pkg::FUNC_SET, idx, spd, dir);
   endtask

   // Tick fields carry noise; the block must ignore them.
   task automatic tick_cmd();
      issue(mcs_pkg::FUNC_TICK, 3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)),
            2'($urandom_range(0, 3)));
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (beats_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [mcs_pkg::SPEED_W-1:0] lim);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Watchdog: end the run if no beat of any kind moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("motor_command_sequencer_top verification failed");
      $finish;
   end

   initial begin
      logic [mcs_pkg::SPEED_W-1:0] limits [LIMIT_STEPS];
      logic [mcs_pkg::SPEED_W-1:0] lim;
      logic [mcs_pkg::SPEED_W-1:0] spd;
      logic [2:0]                  idx;
      logic [1:0]                  dir;
      int                          pick;
      reset           = 1'b1;
      start           = 1'b0;
      req_func        = mcs_pkg::FUNC_SET;
      req_motor_index = '0;
      req_speed       = '0;
      req_direction   = mcs_pkg::DIR_CODE_FWD;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      no_gaps         = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part, limit at its reset value
      tick_cmd();                                         // nothing pending: idle beat
      set_cmd(3'd0, 12'd2400, mcs_pkg::DIR_CODE_FWD);     // speed at the limit
      set_cmd(3'd1, 12'd2401, mcs_pkg::DIR_CODE_BWD);     // just over the limit
      set_cmd(3'd2, 12'd100, DIR_CODE_NONE);              // zero direction is invalid
      set_cmd(3'd3, 12'd50, DIR_CODE_NEG2);               // minus two is invalid
      set_cmd(3'd4, 12'd4095, mcs_pkg::DIR_CODE_BWD);     // full-scale speed
      set_cmd(3'd5, 12'd77, mcs_pkg::DIR_CODE_FWD);       // motor out of range: drop
      set_cmd(3'd7, 12'd4095, mcs_pkg::DIR_CODE_BWD);
      tick_cmd();
      set_cmd(3'd0, 12'd300, mcs_pkg::DIR_CODE_BWD);      // reverse while running
      tick_cmd();
      tick_cmd();
      tick_cmd();
      set_cmd(3'd4, 12'd0, mcs_pkg::DIR_CODE_BWD);        // turn at standstill plus stop
      set_cmd(3'd1, 12'd1000, mcs_pkg::DIR_CODE_BWD);
      set_cmd(3'd1, 12'd1234, mcs_pkg::DIR_CODE_FWD);     // overwrite before the tick
      tick_cmd();
      set_cmd(3'd0, 12'd0, mcs_pkg::DIR_CODE_FWD);
      tick_cmd();
      tick_cmd();
      set_cmd(3'd2, 12'd2000, mcs_pkg::DIR_CODE_BWD);     // stays pending across the write
      write_limit(12'd100);
      tick_cmd();
      tick_cmd();

      // random part over several limits, extremes included
      limits[0] = 12'd4095;
      limits[1] = 12'd0;
      limits[2] = 12'($urandom_range(1, 4094));
      limits[3] = 12'd1;
      limits[4] = mcs_pkg::SPEED_LIMIT_RESET;
      for (int p = 0; p < LIMIT_STEPS; p++) begin
         lim = limits[p];
         write_limit(lim);
         for (int i = 0; i < RANDOM_ITEMS / LIMIT_STEPS; i++) begin
            if (i % 16 == 0)
               no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               tick_cmd();
            end else begin
               idx  = ($urandom_range(0, 9) == 0)
                      ? 3'($urandom_range(mcs_pkg::NUM_MOTORS, 7))
                      : 3'($urandom_range(0, mcs_pkg::NUM_MOTORS - 1));
               pick = $urandom_range(0, 9);
               if (pick < 4)
                  dir = mcs_pkg::DIR_CODE_FWD;
               else if (pick < 8)
                  dir = mcs_pkg::DIR_CODE_BWD;
               else if (pick == 8)
                  dir = DIR_CODE_NONE;
               else
                  dir = DIR_CODE_NEG2;
               pick = $urandom_range(0, 9);
               case (pick)
                  0: spd = '0;
                  1: spd = lim;
                  2: spd = 12'd4095;
                  3: spd = (lim < 12'd4095) ? 12'($urandom_range(lim + 1, 4095)) : 12'd4095;
                  default: spd = 12'($urandom_range(0, lim));
               endcase
               set_cmd(idx, spd, dir);
            end
         end
      end
      no_gaps = 1'b0;

      settle();
      if (mismatch_count == 0 && beats_due == 0)
         $display("motor_command_sequencer_top verification clean");
      else
         $display("motor_command_sequencer_top verification failed");
      $finish;
   end

endmodule
